/* rtl/phe_pkg.sv */
// Shared types and constants for the Horner polynomial evaluator.
package phe_pkg;

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DEG_W      = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int NUM_COEFFS = 7;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic        [DEG_W-1:0]  deg_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   // register map
   localparam csr_idx_type CSR_DEGREE     = 4'd0;
   localparam csr_idx_type CSR_COEFF_BASE = 4'd1;

endpackage

/* rtl/polynomial_horner_eval_unit.sv */
// Horner polynomial evaluator: pipelined multiply / round / add / saturate chain.
//
// Input channel req_*: one signed Q16.16 sample x per transfer. Result channel
// rsp_*: y = sum of coeff_k * x^k up to the programmed degree, saturated to
// 32 bits, plus a flag set if any step clamped. One result per sample, in order.
// Configuration channel csr_*: index 0 is the degree (only its low DEG_W bits are
// kept; values above MAX_DEGREE act as MAX_DEGREE), index 1 + k is coeff_k; other
// indices are dropped. csr_ready is always high; write only while no sample is in flight.
// Each Horner step takes two stages (multiply, then round/add/saturate), and every
// sample passes through every step whatever the programmed degree; steps above the
// degree pass the accumulator through. Throughput is one sample per cycle while
// rsp_stall is low; each step has its own multiplier.
// Each stage has its own valid bit and holds its data while the stage after it is
// full and stalled, so bubbles close up; req_stall rises only once every stage is
// full behind a stalled result. Synchronous reset empties the pipeline and clears
// the degree and all coefficients to zero.
module polynomial_horner_eval_unit #(
   parameter int MAX_DEGREE = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  phe_pkg::data_type      req_x_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output phe_pkg::data_type      rsp_y_value,
   output logic                   rsp_saturated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  phe_pkg::csr_idx_type   csr_index,
   input  phe_pkg::data_type      csr_data
);

   localparam int N      = MAX_DEGREE;
   localparam int CIDX_W = (MAX_DEGREE + 1 > 1) ? $clog2(MAX_DEGREE + 1) : 1;
   localparam phe_pkg::prod_type HALF = phe_pkg::prod_type'(64'sd1 <<< (FRAC_BITS - 1));
   localparam phe_pkg::deg_type  DEG_MAX = phe_pkg::deg_type'(MAX_DEGREE);

   // configuration registers
   phe_pkg::deg_type  degree_ff;
   phe_pkg::data_type coeff_ff [0:MAX_DEGREE];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         for (int k = 0; k <= MAX_DEGREE; k++) begin
            coeff_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         if (csr_index == phe_pkg::CSR_DEGREE) begin
            degree_ff <= csr_data[phe_pkg::DEG_W-1:0];
         end
         for (int k = 0; k <= MAX_DEGREE; k++) begin
            if (csr_index == phe_pkg::CSR_COEFF_BASE + phe_pkg::csr_idx_type'(k)) begin
               coeff_ff[k] <= csr_data;
            end
         end
      end
   end

   phe_pkg::deg_type deg_clamp;
   assign deg_clamp = (degree_ff > DEG_MAX) ? DEG_MAX : degree_ff;

   // pipeline: step j handles coefficient k = N-1-j; M = multiply, A = round/add/sat
   logic              m_valid_ff [0:N-1];
   phe_pkg::prod_type m_prod_ff  [0:N-1];
   phe_pkg::data_type m_acc_ff   [0:N-1];
   phe_pkg::data_type m_x_ff     [0:N-1];
   phe_pkg::deg_type  m_deg_ff   [0:N-1];
   logic              m_sat_ff   [0:N-1];

   logic              a_valid_ff [0:N-1];
   phe_pkg::data_type a_acc_ff   [0:N-1];
   phe_pkg::data_type a_x_ff     [0:N-1];
   phe_pkg::deg_type  a_deg_ff   [0:N-1];
   logic              a_sat_ff   [0:N-1];

   logic              m_ready    [0:N-1];
   logic              a_ready    [0:N-1];
   logic              src_valid  [0:N-1];
   phe_pkg::data_type src_acc    [0:N-1];
   phe_pkg::data_type src_x      [0:N-1];
   phe_pkg::deg_type  src_deg    [0:N-1];
   logic              src_sat    [0:N-1];

   for (genvar j = 0; j < N; j++) begin : g_step
      localparam phe_pkg::deg_type K = phe_pkg::deg_type'(N - 1 - j);

      phe_pkg::prod_type m_prod_in;
      phe_pkg::prod_type rnd;
      phe_pkg::prod_type sum;
      logic              sat_hi;
      logic              sat_lo;
      phe_pkg::data_type a_acc_in;
      logic              a_sat_in;

      if (j == 0) begin : g_src_in
         assign src_valid[j] = req_valid;
         assign src_acc[j]   = coeff_ff[deg_clamp[CIDX_W-1:0]];
         assign src_x[j]     = req_x_value;
         assign src_deg[j]   = deg_clamp;
         assign src_sat[j]   = 1'b0;
      end else begin : g_src_prev
         assign src_valid[j] = a_valid_ff[j-1];
         assign src_acc[j]   = a_acc_ff[j-1];
         assign src_x[j]     = a_x_ff[j-1];
         assign src_deg[j]   = a_deg_ff[j-1];
         assign src_sat[j]   = a_sat_ff[j-1];
      end

      if (j == N - 1) begin : g_rdy_last
         assign a_ready[j] = !a_valid_ff[j] || !rsp_stall;
      end else begin : g_rdy_mid
         assign a_ready[j] = !a_valid_ff[j] || m_ready[j+1];
      end
      assign m_ready[j] = !m_valid_ff[j] || a_ready[j];

      assign m_prod_in = src_acc[j] * src_x[j];

      always_comb begin
         rnd    = (m_prod_ff[j] + HALF) >>> FRAC_BITS;
         sum    = rnd + phe_pkg::prod_type'(coeff_ff[K]);
         sat_hi = !sum[phe_pkg::PROD_W-1] && (|sum[phe_pkg::PROD_W-2:phe_pkg::DATA_W-1]);
         sat_lo = sum[phe_pkg::PROD_W-1] && !(&sum[phe_pkg::PROD_W-2:phe_pkg::DATA_W-1]);
         if (m_deg_ff[j] > K) begin
            priority if (sat_hi) begin
               a_acc_in = {1'b0, {(phe_pkg::DATA_W-1){1'b1}}};
            end else if (sat_lo) begin
               a_acc_in = {1'b1, {(phe_pkg::DATA_W-1){1'b0}}};
            end else begin
               a_acc_in = sum[phe_pkg::DATA_W-1:0];
            end
            a_sat_in = m_sat_ff[j] || sat_hi || sat_lo;
         end else begin
            a_acc_in = m_acc_ff[j];
            a_sat_in = m_sat_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            m_valid_ff[j] <= 1'b0;
            a_valid_ff[j] <= 1'b0;
         end else begin
            if (m_ready[j]) begin
               m_valid_ff[j] <= src_valid[j];
            end
            if (a_ready[j]) begin
               a_valid_ff[j] <= m_valid_ff[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (m_ready[j] && src_valid[j]) begin
            m_prod_ff[j] <= m_prod_in;
            m_acc_ff[j]  <= src_acc[j];
            m_x_ff[j]    <= src_x[j];
            m_deg_ff[j]  <= src_deg[j];
            m_sat_ff[j]  <= src_sat[j];
         end
         if (a_ready[j] && m_valid_ff[j]) begin
            a_acc_ff[j] <= a_acc_in;
            a_x_ff[j]   <= m_x_ff[j];
            a_deg_ff[j] <= m_deg_ff[j];
            a_sat_ff[j] <= a_sat_in;
         end
      end
   end

   assign req_stall     = !m_ready[0];
   assign rsp_valid     = a_valid_ff[N-1];
   assign rsp_y_value   = a_acc_ff[N-1];
   assign rsp_saturated = a_sat_ff[N-1];

   // degree zero takes no step, so it can never clamp
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && a_deg_ff[N-1] == '0) |-> !rsp_saturated)
      else $error("saturation flagged on a degree-zero result");

   // an empty first stage never back-pressures the input
   assert property (@(posedge clock) disable iff (reset)
      !m_valid_ff[0] |-> !req_stall)
      else $error("input stalled with first stage empty");

   // a flag raised in the multiply stage survives into the add stage
   assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff[0] && a_ready[0] && m_sat_ff[0]) |=> a_sat_ff[0])
      else $error("saturation flag lost between stages");

   // reset empties the output stage
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
